// ===== rtl/core/emim_pkg.sv =====
// Shared types and constants for the multi-cell EMA imbalance monitor.
package emim_pkg;

  localparam int MV_W        = 13;  // millivolt fields
  localparam int FILT_W      = 21;  // filtered value in 1/256 mV
  localparam int ADC_W       = 12;  // saturated ADC count
  localparam int ALPHA_W     = 9;
  localparam int FIELD_CELLS = 4;   // cell fields carried by one item
  localparam int FSEL_W      = 2;
  localparam int OUT_IDX_W   = 3;
  localparam int TOTAL_W     = 15;
  localparam int PCT_W       = 14;
  localparam int PROD_W      = 25;  // count times full scale
  localparam int EST_W       = PROD_W + 9;
  localparam int CORR_W      = 14;  // width of the reciprocal correction remainder
  localparam int PM_W        = FILT_W + PCT_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int QUEUE_DEPTH = 2;

  localparam int DIV_BITS_PER_CYC = 2;
  localparam int DIV_CYCLES       = PCT_W / DIV_BITS_PER_CYC;
  localparam int DIV_CNT_W        = 3;

  localparam logic [ADC_W-1:0]   ADC_MAX     = 12'd4095;
  localparam logic [FILT_W-1:0]  RESET_FILT  = 21'd947200;
  localparam logic [FILT_W-1:0]  LOW_MAX_Q8  = 21'd25600;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 15'd32767;
  localparam logic [PCT_W-1:0]   PCT_SCALE   = 14'd10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd51;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX   = 9'd256;
  localparam logic [MV_W-1:0]    FS_RESET    = 13'd4200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA      = 1'b0,
    REG_FULL_SCALE = 1'b1
  } cfg_reg_t;

  // One classified item: override flag and per-field values, counts already saturated.
  typedef struct packed {
    logic                                ovr;
    logic [FIELD_CELLS-1:0][MV_W-1:0]    val;
  } item_t;

  typedef struct packed {
    logic [FIELD_CELLS-1:0][MV_W-1:0] cell_mv;
    logic [OUT_IDX_W-1:0]             weakest;
    logic [OUT_IDX_W-1:0]             strongest;
    logic [MV_W-1:0]                  min_mv;
    logic [MV_W-1:0]                  max_mv;
    logic [TOTAL_W-1:0]               total_mv;
    logic [MV_W-1:0]                  average_mv;
    logic [MV_W-1:0]                  imbalance_mv;
    logic [PCT_W-1:0]                 pct_x100;
  } res_t;

endpackage

// ===== rtl/core/emim_front.sv =====
// Front end: configuration registers and the input stage that classifies and saturates items.
module emim_front (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              cfg_valid,
  output logic                                              cfg_ready,
  input  logic [emim_pkg::CFG_IDX_W-1:0]                    cfg_index,
  input  logic [emim_pkg::CFG_DATA_W-1:0]                   cfg_data,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic                                              in_func,
  input  logic [emim_pkg::FIELD_CELLS-1:0][emim_pkg::MV_W-1:0] in_val,
  output logic                                              push_valid,
  input  logic                                              push_ready,
  output emim_pkg::item_t                                   push_item,
  output logic [emim_pkg::ALPHA_W-1:0]                      alpha,
  output logic [emim_pkg::MV_W-1:0]                         full_scale
);

  logic [emim_pkg::ALPHA_W-1:0] alpha_r;
  logic [emim_pkg::MV_W-1:0]    fs_r;
  logic [emim_pkg::ALPHA_W-1:0] alpha_wr;
  logic                         fr_valid_r;
  emim_pkg::item_t              fr_item_r;
  emim_pkg::item_t              item_nxt;
  logic                         in_acc;

  assign cfg_ready  = 1'b1;
  assign alpha      = alpha_r;
  assign full_scale = fs_r;
  assign alpha_wr   = cfg_data[emim_pkg::ALPHA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= emim_pkg::ALPHA_RESET;
      fs_r    <= emim_pkg::FS_RESET;
    end else if (cfg_valid) begin
      case (emim_pkg::cfg_reg_t'(cfg_index))
        emim_pkg::REG_ALPHA: begin
          // Weights outside 1..256 are dropped and the old weight stays.
          if (alpha_wr != '0 && alpha_wr <= emim_pkg::ALPHA_MAX) begin
            alpha_r <= alpha_wr;
          end
        end
        emim_pkg::REG_FULL_SCALE: begin
          fs_r <= cfg_data[emim_pkg::MV_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item_nxt.ovr = in_func;
    for (int i = 0; i < emim_pkg::FIELD_CELLS; i++) begin
      if (!in_func && in_val[i] > emim_pkg::MV_W'(emim_pkg::ADC_MAX)) begin
        item_nxt.val[i] = emim_pkg::MV_W'(emim_pkg::ADC_MAX);
      end else begin
        item_nxt.val[i] = in_val[i];
      end
    end
  end

  assign in_ready   = !fr_valid_r || push_ready;
  assign in_acc     = in_valid && in_ready;
  assign push_valid = fr_valid_r;
  assign push_item  = fr_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_acc) begin
      fr_valid_r <= 1'b1;
    end else if (push_ready) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fr_item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/core/emim_queue.sv =====
// Short item queue between the front end and the back end.
module emim_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  emim_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output emim_pkg::item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  emim_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            push;
  logic            pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/emim_back.sv =====
// Back end: per-cell filter pipeline, pack statistics, percentage divider and result register.
module emim_back #(
  parameter int CELL_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  emim_pkg::item_t               item,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [emim_pkg::ALPHA_W-1:0]  alpha,
  input  logic [emim_pkg::MV_W-1:0]     full_scale,
  output emim_pkg::res_t                res,
  output logic                          res_valid,
  input  logic                          res_ready
);

  localparam int CIW    = $clog2(CELL_COUNT);
  localparam int CNTW   = $clog2(CELL_COUNT + 1);
  localparam int IXW    = (CIW + 1 > emim_pkg::OUT_IDX_W) ? CIW + 1 : emim_pkg::OUT_IDX_W;
  localparam int SW     = emim_pkg::FILT_W + CIW;
  localparam int TIN_W  = SW - 8;
  localparam int TSW    = (TIN_W > emim_pkg::TOTAL_W) ? TIN_W : emim_pkg::TOTAL_W;
  localparam int AVG_SH = TIN_W + CIW;
  localparam int AVG_PW = TIN_W + AVG_SH;
  localparam int unsigned AVG_RECIP_I = ((1 << AVG_SH) + CELL_COUNT - 1) / CELL_COUNT;
  localparam logic [AVG_SH-1:0] AVG_RECIP = AVG_SH'(AVG_RECIP_I);

  localparam int FW = emim_pkg::FILT_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CELLS = 5'b00010,
    ST_STATS = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  function automatic logic [FW:0] div_step(input logic [FW-1:0] rem,
                                           input logic nb,
                                           input logic [FW-1:0] den);
    logic [FW:0] sh;
    logic [FW:0] df;
    begin
      sh = {rem, nb};
      df = sh - {1'b0, den};
      if (sh >= {1'b0, den}) begin
        return {df[FW-1:0], 1'b1};
      end else begin
        return {sh[FW-1:0], 1'b0};
      end
    end
  endfunction

  state_t                           state_r;
  state_t                           state_nxt;
  emim_pkg::item_t                  item_r;
  logic [CNTW-1:0]                  iss_r;

  logic                             p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  logic [CIW-1:0]                   p1_idx_r, p2_idx_r, p3_idx_r, p4_idx_r;
  logic [emim_pkg::PROD_W-1:0]      p1_prod_r;
  logic [FW-1:0]                    p2_q_r;
  logic [emim_pkg::CORR_W-1:0]      p2_ylo_r;
  logic [FW-1:0]                    p3_raw_r;
  logic [FW-1:0]                    p4_new_r;
  logic [FW-1:0]                    filt_r [CELL_COUNT];

  logic [FW-1:0]                    st_min_r, st_max_r;
  logic [CIW-1:0]                   st_weak_r, st_strong_r;
  logic [SW-1:0]                    st_sum_r;
  logic [emim_pkg::TOTAL_W-1:0]     total_r;
  logic [AVG_PW-1:0]                avg_prod_r;

  logic [FW-1:0]                    div_rem_r;
  logic [emim_pkg::PCT_W-1:0]       div_lo_r;
  logic [emim_pkg::PCT_W-1:0]       div_q_r;
  logic [emim_pkg::DIV_CNT_W-1:0]   div_cnt_r;

  emim_pkg::res_t                   res_r;
  emim_pkg::res_t                   res_nxt;
  logic                             res_valid_r;

  logic                             accept;
  logic                             issue;
  logic [CIW-1:0]                   iss_idx;
  logic [IXW-1:0]                   idx_w;
  logic [emim_pkg::FSEL_W-1:0]      fsel;
  logic [emim_pkg::MV_W-1:0]        field_v;
  logic [emim_pkg::PROD_W-1:0]      prod_nxt;
  logic [emim_pkg::EST_W-1:0]       est_num;
  logic [FW-1:0]                    q_nxt;
  logic [emim_pkg::CORR_W-1:0]      r_corr;
  logic [FW-1:0]                    raw_nxt;
  logic [FW-1:0]                    filt_cur;
  logic signed [FW:0]               diff;
  logic signed [FW+10:0]            mprod;
  logic [FW+11:0]                   mix;
  logic [FW-1:0]                    new_nxt;
  logic                             last_cell;
  logic [FW-1:0]                    spread;
  logic [emim_pkg::PM_W-1:0]        pmul;
  logic [TIN_W-1:0]                 tsum;
  logic [TSW-1:0]                   tsum_w;
  logic [emim_pkg::TOTAL_W-1:0]     total_nxt;
  logic [FW-1:0]                    rem_nxt;
  logic [emim_pkg::PCT_W-1:0]       lo_nxt;
  logic [emim_pkg::PCT_W-1:0]       q_div_nxt;
  logic                             div_done;
  logic                             load_res;
  logic [IXW-1:0]                   weak_w, strong_w;
  logic [emim_pkg::FIELD_CELLS-1:0][emim_pkg::MV_W-1:0] cell_mv_w;

  assign item_ready = (state_r == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign res        = res_r;
  assign res_valid  = res_valid_r;

  // Issue side: one cell enters the filter pipeline per cycle.
  assign issue   = (state_r == ST_CELLS) && (iss_r < CNTW'(CELL_COUNT));
  assign iss_idx = iss_r[CIW-1:0];
  assign idx_w   = IXW'(iss_idx);
  // Cells past the fourth reuse the last field.
  assign fsel    = (idx_w < IXW'(emim_pkg::FIELD_CELLS)) ? idx_w[emim_pkg::FSEL_W-1:0]
                                                         : emim_pkg::FSEL_W'(emim_pkg::FIELD_CELLS - 1);
  assign field_v = item_r.val[fsel];
  assign prod_nxt = item_r.ovr ? emim_pkg::PROD_W'(field_v)
                               : emim_pkg::PROD_W'(field_v[emim_pkg::ADC_W-1:0]) *
                                 emim_pkg::PROD_W'(full_scale);

  // x*256/4095 by the series 1/4096 + 1/4096^2 + 1/4096^3; the estimate is low by at most one.
  assign est_num = (emim_pkg::EST_W'(p1_prod_r) << 8) + emim_pkg::EST_W'(p1_prod_r >> 4) +
                   emim_pkg::EST_W'(p1_prod_r >> 16);
  assign q_nxt   = item_r.ovr ? {p1_prod_r[emim_pkg::MV_W-1:0], 8'd0} : est_num[FW+11:12];

  // Remainder y - q*4095 is below 8190, so 14 bits of modular arithmetic are exact.
  assign r_corr  = p2_ylo_r - {p2_q_r[1:0], 12'd0} + p2_q_r[emim_pkg::CORR_W-1:0];
  assign raw_nxt = (!item_r.ovr && r_corr >= emim_pkg::CORR_W'(emim_pkg::ADC_MAX)) ?
                   p2_q_r + 1'b1 : p2_q_r;

  // alpha*raw + (256-alpha)*filt is rewritten as 256*filt + alpha*(raw-filt).
  assign filt_cur = filt_r[p3_idx_r];
  assign diff     = $signed({1'b0, p3_raw_r}) - $signed({1'b0, filt_cur});
  assign mprod    = $signed({1'b0, alpha}) * diff;
  assign mix      = {4'd0, filt_cur, 8'd0} + {mprod[FW+10], mprod};
  assign new_nxt  = item_r.ovr ? p3_raw_r : mix[FW+7:8];

  assign last_cell = p4_v_r && (p4_idx_r == CIW'(CELL_COUNT - 1));

  assign spread    = st_max_r - st_min_r;
  assign pmul      = emim_pkg::PM_W'(spread) * emim_pkg::PM_W'(emim_pkg::PCT_SCALE);
  assign tsum      = st_sum_r[SW-1:8];
  assign tsum_w    = TSW'(tsum);
  assign total_nxt = (tsum_w > TSW'(emim_pkg::TOTAL_MAX)) ? emim_pkg::TOTAL_MAX
                                                          : tsum_w[emim_pkg::TOTAL_W-1:0];

  always_comb begin
    logic [FW:0] step;
    rem_nxt   = div_rem_r;
    lo_nxt    = div_lo_r;
    q_div_nxt = div_q_r;
    for (int k = 0; k < emim_pkg::DIV_BITS_PER_CYC; k++) begin
      step      = div_step(rem_nxt, lo_nxt[emim_pkg::PCT_W-1], st_max_r);
      rem_nxt   = step[FW:1];
      q_div_nxt = {q_div_nxt[emim_pkg::PCT_W-2:0], step[0]};
      lo_nxt    = lo_nxt << 1;
    end
  end

  assign div_done = (div_cnt_r == emim_pkg::DIV_CNT_W'(emim_pkg::DIV_CYCLES - 1));
  assign load_res = (state_r == ST_OUT) && (!res_valid_r || res_ready);

  for (genvar g = 0; g < emim_pkg::FIELD_CELLS; g++) begin : g_cell_out
    if (g < CELL_COUNT) begin : g_on
      assign cell_mv_w[g] = filt_r[g][FW-1:8];
    end else begin : g_off
      assign cell_mv_w[g] = '0;
    end
  end

  assign weak_w   = IXW'(st_weak_r) + IXW'(1);
  assign strong_w = IXW'(st_strong_r) + IXW'(1);

  always_comb begin
    res_nxt.cell_mv      = cell_mv_w;
    res_nxt.weakest      = weak_w[emim_pkg::OUT_IDX_W-1:0];
    res_nxt.strongest    = strong_w[emim_pkg::OUT_IDX_W-1:0];
    res_nxt.min_mv       = st_min_r[FW-1:8];
    res_nxt.max_mv       = st_max_r[FW-1:8];
    res_nxt.total_mv     = total_r;
    res_nxt.average_mv   = avg_prod_r[AVG_SH +: emim_pkg::MV_W];
    res_nxt.imbalance_mv = spread[FW-1:8];
    res_nxt.pct_x100     = (st_max_r < emim_pkg::LOW_MAX_Q8) ? '0 : div_q_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CELLS;
        end
      end
      ST_CELLS: begin
        if (last_cell) begin
          state_nxt = ST_STATS;
        end
      end
      ST_STATS: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_res) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      p4_v_r      <= 1'b0;
      res_valid_r <= 1'b0;
      for (int i = 0; i < CELL_COUNT; i++) begin
        filt_r[i] <= emim_pkg::RESET_FILT;
      end
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        iss_r <= '0;
      end else if (issue) begin
        iss_r <= iss_r + 1'b1;
      end
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
      if (p4_v_r) begin
        filt_r[p4_idx_r] <= p4_new_r;
      end
      if (load_res) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item;
    end
    p1_idx_r  <= iss_idx;
    p1_prod_r <= prod_nxt;
    p2_idx_r  <= p1_idx_r;
    p2_q_r    <= q_nxt;
    p2_ylo_r  <= {p1_prod_r[5:0], 8'd0};
    p3_idx_r  <= p2_idx_r;
    p3_raw_r  <= raw_nxt;
    p4_idx_r  <= p3_idx_r;
    p4_new_r  <= new_nxt;

    // Running statistics in cell order; strict compares keep the first cell on ties.
    if (p4_v_r) begin
      if (p4_idx_r == '0) begin
        st_min_r    <= p4_new_r;
        st_max_r    <= p4_new_r;
        st_weak_r   <= '0;
        st_strong_r <= '0;
        st_sum_r    <= SW'(p4_new_r);
      end else begin
        if (p4_new_r < st_min_r) begin
          st_min_r  <= p4_new_r;
          st_weak_r <= p4_idx_r;
        end
        if (p4_new_r > st_max_r) begin
          st_max_r    <= p4_new_r;
          st_strong_r <= p4_idx_r;
        end
        st_sum_r <= st_sum_r + SW'(p4_new_r);
      end
    end

    if (state_r == ST_STATS) begin
      total_r    <= total_nxt;
      avg_prod_r <= AVG_PW'(tsum) * AVG_PW'(AVG_RECIP);
      // The quotient is below 2^14, so the upper dividend bits are already below the divisor.
      div_rem_r  <= pmul[emim_pkg::PM_W-1:emim_pkg::PCT_W];
      div_lo_r   <= pmul[emim_pkg::PCT_W-1:0];
      div_q_r    <= '0;
      div_cnt_r  <= '0;
    end else if (state_r == ST_DIV) begin
      div_rem_r <= rem_nxt;
      div_lo_r  <= lo_nxt;
      div_q_r   <= q_div_nxt;
      div_cnt_r <= div_cnt_r + 1'b1;
    end

    if (load_res) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/core/multi_cell_ema_imbalance_monitor.sv =====
// Multi-cell EMA filter with min/max tracking and imbalance statistics, top level.
// The back end works on one item at a time and finishes it before it accepts the next: it takes
// the item, runs each cell through the filter pipeline, updates the statistics, runs the
// percentage divider and posts the result.
// The front stage and two-entry queue hold up to three further items.
// Synchronous active-low reset: alpha 51, full scale 4200 mV, every cell at 3700 mV.
module multi_cell_ema_imbalance_monitor #(
  parameter int CELL_COUNT = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [emim_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [emim_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [emim_pkg::MV_W-1:0]           in_cell_a_value,
  input  logic [emim_pkg::MV_W-1:0]           in_cell_b_value,
  input  logic [emim_pkg::MV_W-1:0]           in_cell_c_value,
  input  logic [emim_pkg::MV_W-1:0]           in_cell_d_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [emim_pkg::MV_W-1:0]           out_cell_a_mv,
  output logic [emim_pkg::MV_W-1:0]           out_cell_b_mv,
  output logic [emim_pkg::MV_W-1:0]           out_cell_c_mv,
  output logic [emim_pkg::MV_W-1:0]           out_cell_d_mv,
  output logic [emim_pkg::OUT_IDX_W-1:0]      out_weakest_cell,
  output logic [emim_pkg::OUT_IDX_W-1:0]      out_strongest_cell,
  output logic [emim_pkg::MV_W-1:0]           out_min_mv,
  output logic [emim_pkg::MV_W-1:0]           out_max_mv,
  output logic [emim_pkg::TOTAL_W-1:0]        out_total_mv,
  output logic [emim_pkg::MV_W-1:0]           out_average_mv,
  output logic [emim_pkg::MV_W-1:0]           out_imbalance_mv,
  output logic [emim_pkg::PCT_W-1:0]          out_imbalance_pct_x100
);

  logic [emim_pkg::FIELD_CELLS-1:0][emim_pkg::MV_W-1:0] in_val;
  logic                          push_valid;
  logic                          push_ready;
  emim_pkg::item_t               push_item;
  logic                          pop_valid;
  logic                          pop_ready;
  emim_pkg::item_t               pop_item;
  logic [emim_pkg::ALPHA_W-1:0]  alpha;
  logic [emim_pkg::MV_W-1:0]     full_scale;
  emim_pkg::res_t                res;

  assign in_val[0] = in_cell_a_value;
  assign in_val[1] = in_cell_b_value;
  assign in_val[2] = in_cell_c_value;
  assign in_val[3] = in_cell_d_value;

  emim_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_val     (in_val),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .alpha      (alpha),
    .full_scale (full_scale)
  );

  emim_queue #(
    .DEPTH (emim_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  emim_back #(
    .CELL_COUNT (CELL_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (pop_item),
    .item_valid (pop_valid),
    .item_ready (pop_ready),
    .alpha      (alpha),
    .full_scale (full_scale),
    .res        (res),
    .res_valid  (out_valid),
    .res_ready  (out_ready)
  );

  assign out_cell_a_mv          = res.cell_mv[0];
  assign out_cell_b_mv          = res.cell_mv[1];
  assign out_cell_c_mv          = res.cell_mv[2];
  assign out_cell_d_mv          = res.cell_mv[3];
  assign out_weakest_cell       = res.weakest;
  assign out_strongest_cell     = res.strongest;
  assign out_min_mv             = res.min_mv;
  assign out_max_mv             = res.max_mv;
  assign out_total_mv           = res.total_mv;
  assign out_average_mv         = res.average_mv;
  assign out_imbalance_mv       = res.imbalance_mv;
  assign out_imbalance_pct_x100 = res.pct_x100;

endmodule

// ===== rtl/core/emim_checker.sv =====
// Port-level assertions for the monitor and the bind that attaches them.
module emim_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [emim_pkg::MV_W-1:0]       out_min_mv,
  input logic [emim_pkg::MV_W-1:0]       out_max_mv,
  input logic [emim_pkg::MV_W-1:0]       out_imbalance_mv,
  input logic [emim_pkg::PCT_W-1:0]      out_imbalance_pct_x100
);

  // Front register, queue, back end and result register.
  localparam int MAX_INFLIGHT = emim_pkg::QUEUE_DEPTH + 3;
  localparam logic [emim_pkg::MV_W-1:0] LOW_MV = 13'd100;

  logic [3:0] inflight_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> inflight_r != '0)
    else $error("result delivered with no item outstanding");

  a_bounded_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 4'(MAX_INFLIGHT))
    else $error("more items outstanding than the block can hold");

  a_spread_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_mv <= out_max_mv) &&
                  (({1'b0, out_imbalance_mv} == {1'b0, out_max_mv} - {1'b0, out_min_mv}) ||
                   ({1'b0, out_imbalance_mv} + 14'd1 == {1'b0, out_max_mv} - {1'b0, out_min_mv})))
    else $error("imbalance does not match max and min");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_imbalance_pct_x100 <= emim_pkg::PCT_SCALE) &&
                  ((out_max_mv >= LOW_MV) || (out_imbalance_pct_x100 == '0)))
    else $error("imbalance percentage out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_mv) && $stable(out_min_mv))
    else $error("stalled result changed");

endmodule

bind multi_cell_ema_imbalance_monitor emim_checker u_emim_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_min_mv             (out_min_mv),
  .out_max_mv             (out_max_mv),
  .out_imbalance_mv       (out_imbalance_mv),
  .out_imbalance_pct_x100 (out_imbalance_pct_x100)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the multi-cell EMA imbalance monitor.
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 6;
  localparam int IDLE_PCT        = 25;
  localparam int MAX_GAP         = 24;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int MAX_PRINTED     = 40;

  typedef longint unsigned u64_t;
  localparam u64_t Q8_ONE = 256;

  typedef enum logic {
    FN_SAMPLE   = 1'b0,
    FN_OVERRIDE = 1'b1
  } cell_func_t;

  typedef struct packed {
    cell_func_t                                           func;
    logic [emim_pkg::FIELD_CELLS-1:0][emim_pkg::MV_W-1:0] val;
  } cell_reading_t;

  typedef struct packed {
    emim_pkg::cfg_reg_t              idx;
    logic [emim_pkg::CFG_DATA_W-1:0] data;
  } cfg_write_t;

  // Keeps its own copy of the filter state and registers and predicts one pack report
  // per accepted reading.
  class pack_stats_scoreboard;
    int unsigned                 alpha_q8;
    int unsigned                 full_scale_mv;
    logic [emim_pkg::FILT_W-1:0] filt_q8 [emim_pkg::FIELD_CELLS];
    emim_pkg::res_t              predicted_reports[$];
    int unsigned                 mismatches;

    function new();
      alpha_q8      = emim_pkg::ALPHA_RESET;
      full_scale_mv = emim_pkg::FS_RESET;
      foreach (filt_q8[i]) filt_q8[i] = emim_pkg::RESET_FILT;
      mismatches    = 0;
    endfunction

    function void apply_reg(emim_pkg::cfg_reg_t idx, logic [emim_pkg::CFG_DATA_W-1:0] data);
      logic [emim_pkg::ALPHA_W-1:0] a;
      a = data[emim_pkg::ALPHA_W-1:0];
      if (idx == emim_pkg::REG_ALPHA) begin
        // Alpha writes outside 1..256 leave the register alone.
        if (a != 0 && a <= emim_pkg::ALPHA_MAX) alpha_q8 = a;
      end else begin
        full_scale_mv = data;
      end
    endfunction

    function void note_reading(cell_reading_t rd);
      u64_t                        cnt, raw, mix, sum;
      logic [emim_pkg::FILT_W-1:0] lo, hi;
      int                          weak_idx, strong_idx;
      emim_pkg::res_t              r;
      for (int i = 0; i < emim_pkg::FIELD_CELLS; i++) begin
        if (rd.func == FN_OVERRIDE) begin
          filt_q8[i] = {rd.val[i], 8'd0};
        end else begin
          cnt = (rd.val[i] > emim_pkg::ADC_MAX) ? u64_t'(emim_pkg::ADC_MAX)
                                                : u64_t'(rd.val[i]);
          raw = cnt * full_scale_mv * Q8_ONE / emim_pkg::ADC_MAX;
          mix = alpha_q8 * raw + (Q8_ONE - alpha_q8) * filt_q8[i];
          filt_q8[i] = emim_pkg::FILT_W'(mix >> 8);
        end
      end
      lo = filt_q8[0];
      hi = filt_q8[0];
      weak_idx = 0;
      strong_idx = 0;
      sum = 0;
      for (int i = 0; i < emim_pkg::FIELD_CELLS; i++) begin
        if (filt_q8[i] < lo) begin
          lo = filt_q8[i];
          weak_idx = i;
        end
        if (filt_q8[i] > hi) begin
          hi = filt_q8[i];
          strong_idx = i;
        end
        sum += filt_q8[i];
        r.cell_mv[i] = emim_pkg::MV_W'(filt_q8[i] >> 8);
      end
      r.weakest      = emim_pkg::OUT_IDX_W'(weak_idx + 1);
      r.strongest    = emim_pkg::OUT_IDX_W'(strong_idx + 1);
      r.min_mv       = emim_pkg::MV_W'(lo >> 8);
      r.max_mv       = emim_pkg::MV_W'(hi >> 8);
      r.total_mv     = ((sum >> 8) > emim_pkg::TOTAL_MAX) ? emim_pkg::TOTAL_MAX
                                                          : emim_pkg::TOTAL_W'(sum >> 8);
      r.average_mv   = emim_pkg::MV_W'(sum / (emim_pkg::FIELD_CELLS * Q8_ONE));
      r.imbalance_mv = emim_pkg::MV_W'((hi - lo) >> 8);
      r.pct_x100     = (hi < emim_pkg::LOW_MAX_Q8) ? '0 :
                       emim_pkg::PCT_W'(u64_t'(hi - lo) * emim_pkg::PCT_SCALE / hi);
      predicted_reports.push_back(r);
    endfunction

    function bit busy();
      return predicted_reports.size() != 0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task compare_field(string name, int unsigned got_v, int unsigned want_v);
      if (got_v != want_v)
        report_mismatch($sformatf("%s got %0d, predicted %0d", name, got_v, want_v));
    endtask

    task check_report(emim_pkg::res_t got);
      emim_pkg::res_t want;
      if (predicted_reports.size() == 0) begin
        report_mismatch("report arrived with no item outstanding");
        return;
      end
      want = predicted_reports.pop_front();
      for (int i = 0; i < emim_pkg::FIELD_CELLS; i++)
        compare_field($sformatf("cell_mv[%0d]", i), got.cell_mv[i], want.cell_mv[i]);
      compare_field("weakest_cell", got.weakest, want.weakest);
      compare_field("strongest_cell", got.strongest, want.strongest);
      compare_field("min_mv", got.min_mv, want.min_mv);
      compare_field("max_mv", got.max_mv, want.max_mv);
      compare_field("total_mv", got.total_mv, want.total_mv);
      compare_field("average_mv", got.average_mv, want.average_mv);
      compare_field("imbalance_mv", got.imbalance_mv, want.imbalance_mv);
      compare_field("imbalance_pct_x100", got.pct_x100, want.pct_x100);
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [emim_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [emim_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_func = 1'b0;
  logic [emim_pkg::MV_W-1:0]       in_cell_a_value = '0;
  logic [emim_pkg::MV_W-1:0]       in_cell_b_value = '0;
  logic [emim_pkg::MV_W-1:0]       in_cell_c_value = '0;
  logic [emim_pkg::MV_W-1:0]       in_cell_d_value = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [emim_pkg::MV_W-1:0]       out_cell_a_mv, out_cell_b_mv, out_cell_c_mv, out_cell_d_mv;
  logic [emim_pkg::OUT_IDX_W-1:0]  out_weakest_cell, out_strongest_cell;
  logic [emim_pkg::MV_W-1:0]       out_min_mv, out_max_mv, out_average_mv, out_imbalance_mv;
  logic [emim_pkg::TOTAL_W-1:0]    out_total_mv;
  logic [emim_pkg::PCT_W-1:0]      out_imbalance_pct_x100;

  pack_stats_scoreboard sb;
  int tx_idle_pct = IDLE_PCT;
  int rx_idle_pct = IDLE_PCT;
  bit hold_armed = 1'b0;

  multi_cell_ema_imbalance_monitor dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_func                (in_func),
    .in_cell_a_value        (in_cell_a_value),
    .in_cell_b_value        (in_cell_b_value),
    .in_cell_c_value        (in_cell_c_value),
    .in_cell_d_value        (in_cell_d_value),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_cell_a_mv          (out_cell_a_mv),
    .out_cell_b_mv          (out_cell_b_mv),
    .out_cell_c_mv          (out_cell_c_mv),
    .out_cell_d_mv          (out_cell_d_mv),
    .out_weakest_cell       (out_weakest_cell),
    .out_strongest_cell     (out_strongest_cell),
    .out_min_mv             (out_min_mv),
    .out_max_mv             (out_max_mv),
    .out_total_mv           (out_total_mv),
    .out_average_mv         (out_average_mv),
    .out_imbalance_mv       (out_imbalance_mv),
    .out_imbalance_pct_x100 (out_imbalance_pct_x100)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic cell_reading_t make_reading(cell_func_t f, int a, int b, int c, int d);
    cell_reading_t rd;
    rd.func   = f;
    rd.val[0] = emim_pkg::MV_W'(a);
    rd.val[1] = emim_pkg::MV_W'(b);
    rd.val[2] = emim_pkg::MV_W'(c);
    rd.val[3] = emim_pkg::MV_W'(d);
    return rd;
  endfunction

  function automatic cfg_write_t reg_write(emim_pkg::cfg_reg_t idx, int unsigned data);
    cfg_write_t w;
    w.idx  = idx;
    w.data = emim_pkg::CFG_DATA_W'(data);
    return w;
  endfunction

  function automatic cell_reading_t random_reading();
    cell_reading_t rd;
    rd.func = ($urandom_range(3) == 0) ? FN_OVERRIDE : FN_SAMPLE;
    // Now and then a whole pack near the low-voltage threshold.
    if ($urandom_range(9) == 0) begin
      rd.func = FN_OVERRIDE;
      for (int i = 0; i < emim_pkg::FIELD_CELLS; i++)
        rd.val[i] = emim_pkg::MV_W'($urandom_range(0, 150));
      return rd;
    end
    for (int i = 0; i < emim_pkg::FIELD_CELLS; i++) begin
      case ($urandom_range(7))
        0, 1, 2: rd.val[i] = emim_pkg::MV_W'($urandom_range(0, (1 << emim_pkg::MV_W) - 1));
        3: begin
          if (rd.func == FN_OVERRIDE) rd.val[i] = emim_pkg::MV_W'($urandom_range(2500, 4300));
          else rd.val[i] = emim_pkg::MV_W'($urandom_range(2400, emim_pkg::ADC_MAX));
        end
        4: begin
          case ($urandom_range(3))
            0: rd.val[i] = '0;
            1: rd.val[i] = emim_pkg::MV_W'(emim_pkg::ADC_MAX);
            2: rd.val[i] = emim_pkg::MV_W'(emim_pkg::ADC_MAX) + 1'b1;
            default: rd.val[i] = '1;
          endcase
        end
        5: begin
          // Repeat the previous cell so ties are common.
          if (i > 0) rd.val[i] = rd.val[i-1];
          else rd.val[i] = '0;
        end
        default: rd.val[i] = emim_pkg::MV_W'($urandom_range(90, 110));
      endcase
    end
    return rd;
  endfunction

  task automatic send_readings(input cell_reading_t list[$]);
    foreach (list[k]) begin
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
      end
      in_valid        <= 1'b1;
      in_func         <= list[k].func;
      in_cell_a_value <= list[k].val[0];
      in_cell_b_value <= list[k].val[1];
      in_cell_c_value <= list[k].val[2];
      in_cell_d_value <= list[k].val[3];
      do @(posedge clk); while (!in_ready);
      sb.note_reading(list[k]);
    end
    in_valid <= 1'b0;
  endtask

  task automatic program_regs(input cfg_write_t list[$]);
    foreach (list[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= list[k].idx;
      cfg_data  <= list[k].data;
      do @(posedge clk); while (!cfg_ready);
      sb.apply_reg(list[k].idx, list[k].data);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.busy()) @(posedge clk);
  endtask

  // Result side: random back-pressure plus one long hold-off when armed.
  initial begin : report_sink
    int             hold_left;
    emim_pkg::res_t got;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.cell_mv[0]   = out_cell_a_mv;
        got.cell_mv[1]   = out_cell_b_mv;
        got.cell_mv[2]   = out_cell_c_mv;
        got.cell_mv[3]   = out_cell_d_mv;
        got.weakest      = out_weakest_cell;
        got.strongest    = out_strongest_cell;
        got.min_mv       = out_min_mv;
        got.max_mv       = out_max_mv;
        got.total_mv     = out_total_mv;
        got.average_mv   = out_average_mv;
        got.imbalance_mv = out_imbalance_mv;
        got.pct_x100     = out_imbalance_pct_x100;
        sb.check_report(got);
      end
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    cell_reading_t batch[$];
    cfg_write_t    writes[$];
    int unsigned   alpha_data, fs_data;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: extremes of the inputs, saturation, ties and the low-pack rule.
    batch.push_back(make_reading(FN_SAMPLE, 0, 0, 0, 0));
    batch.push_back(make_reading(FN_SAMPLE, 4095, 4095, 4095, 4095));
    batch.push_back(make_reading(FN_SAMPLE, 8191, 8191, 8191, 8191));
    batch.push_back(make_reading(FN_SAMPLE, 4096, 5000, 1, 'h0AAA));
    batch.push_back(make_reading(FN_OVERRIDE, 8191, 8191, 8191, 8191));
    batch.push_back(make_reading(FN_OVERRIDE, 0, 0, 0, 0));
    batch.push_back(make_reading(FN_OVERRIDE, 99, 99, 99, 99));
    batch.push_back(make_reading(FN_OVERRIDE, 100, 50, 100, 50));
    batch.push_back(make_reading(FN_OVERRIDE, 3700, 3700, 3700, 3700));
    batch.push_back(make_reading(FN_OVERRIDE, 1000, 2000, 2000, 1000));
    batch.push_back(make_reading(FN_OVERRIDE, 5000, 1, 8191, 8191));
    batch.push_back(make_reading(FN_OVERRIDE, 8191, 8191, 8191, 0));
    batch.push_back(make_reading(FN_SAMPLE, 'h1555, 'h0AAA, 'h1555, 'h0AAA));
    send_readings(batch);
    wait_drained();

    // No smoothing at the largest full scale.
    writes.push_back(reg_write(emim_pkg::REG_ALPHA, emim_pkg::ALPHA_MAX));
    writes.push_back(reg_write(emim_pkg::REG_FULL_SCALE, (1 << emim_pkg::MV_W) - 1));
    program_regs(writes);
    batch.delete();
    batch.push_back(make_reading(FN_SAMPLE, 4095, 0, 2048, 8191));
    batch.push_back(make_reading(FN_SAMPLE, 'h0AAA, 'h1555, 'h0AAA, 'h1555));
    batch.push_back(make_reading(FN_OVERRIDE, 4200, 4200, 4200, 4200));
    batch.push_back(make_reading(FN_SAMPLE, 1, 2, 3, 4));
    send_readings(batch);
    wait_drained();

    // Out-of-range alpha writes must leave the previous alpha in place.
    writes.delete();
    writes.push_back(reg_write(emim_pkg::REG_ALPHA, 0));
    writes.push_back(reg_write(emim_pkg::REG_ALPHA, emim_pkg::ALPHA_MAX + 1));
    writes.push_back(reg_write(emim_pkg::REG_FULL_SCALE, 1));
    program_regs(writes);
    batch.delete();
    batch.push_back(make_reading(FN_SAMPLE, 4095, 4095, 0, 100));
    batch.push_back(make_reading(FN_SAMPLE, 8191, 2000, 8191, 3));
    send_readings(batch);
    wait_drained();

    // Heaviest smoothing with a zero full scale.
    writes.delete();
    writes.push_back(reg_write(emim_pkg::REG_ALPHA, 1));
    writes.push_back(reg_write(emim_pkg::REG_FULL_SCALE, 0));
    program_regs(writes);
    batch.delete();
    batch.push_back(make_reading(FN_SAMPLE, 4095, 100, 2000, 0));
    batch.push_back(make_reading(FN_SAMPLE, 8191, 8191, 8191, 8191));
    send_readings(batch);
    wait_drained();

    // Only the low nine bits of alpha count: the first write lands on 256, the second is
    // out of range once masked.
    writes.delete();
    writes.push_back(reg_write(emim_pkg::REG_ALPHA, 'h1100));
    writes.push_back(reg_write(emim_pkg::REG_ALPHA, 'h1101));
    writes.push_back(reg_write(emim_pkg::REG_FULL_SCALE, emim_pkg::FS_RESET));
    program_regs(writes);
    batch.delete();
    batch.push_back(make_reading(FN_SAMPLE, 2000, 2000, 2000, 2000));
    send_readings(batch);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(4))
        0: alpha_data = 1;
        1: alpha_data = emim_pkg::ALPHA_MAX;
        2: alpha_data = emim_pkg::ALPHA_RESET;
        3: alpha_data = $urandom_range(1, emim_pkg::ALPHA_MAX);
        default: alpha_data = $urandom_range(0, (1 << emim_pkg::CFG_DATA_W) - 1);
      endcase
      case ($urandom_range(4))
        0: fs_data = 0;
        1: fs_data = 1;
        2: fs_data = (1 << emim_pkg::MV_W) - 1;
        3: fs_data = emim_pkg::FS_RESET;
        default: fs_data = $urandom_range(0, (1 << emim_pkg::MV_W) - 1);
      endcase
      writes.delete();
      writes.push_back(reg_write(emim_pkg::REG_ALPHA, alpha_data));
      writes.push_back(reg_write(emim_pkg::REG_FULL_SCALE, fs_data));
      program_regs(writes);

      tx_idle_pct = (p == 3 || p == 5) ? 0 : IDLE_PCT;
      rx_idle_pct = (p == 3) ? 0 : IDLE_PCT;
      // The sender keeps offering while the sink holds off, so the input side backs up.
      if (p == 5) hold_armed = 1'b1;

      batch.delete();
      repeat (ITEMS_PER_PHASE) batch.push_back(random_reading());
      send_readings(batch);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
